### src/sed_pkg.sv
// Shared types and constants for the speech endpoint detector.
// No dependencies; used by speech_endpoint_detector_top.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  localparam int MAX_FRAME_LENGTH_DEF = 1024;

  localparam int FRAME_LEN_W = 11;
  localparam int ENERGY_W    = 26;
  localparam int HANGOVER_W  = 8;
  localparam int FRAME_IDX_W = 10;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 26;
  localparam int OUT_DATA_W  = 64;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 11'd160;
  localparam logic [ENERGY_W-1:0]    THRESHOLD_RST = 26'd320000;
  localparam logic [HANGOVER_W-1:0]  HANGOVER_RST  = 8'd15;
  localparam logic [FRAME_IDX_W-1:0] WINDOW_RST    = 10'd75;

  localparam logic [ENERGY_W-1:0]   ENERGY_MAX  = {ENERGY_W{1'b1}};
  localparam logic [HANGOVER_W-1:0] LOW_RUN_MAX = {HANGOVER_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 8'd3;

  typedef struct packed {
    logic                   done_res;
    logic [FRAME_IDX_W-1:0] speech_end;
    logic [FRAME_IDX_W-1:0] speech_start;
    logic                   speech_found;
    logic                   above_threshold;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [ENERGY_W-1:0]    frame_energy;
  } result_t;

endpackage

`default_nettype wire

### src/speech_endpoint_detector_top.sv
// Speech endpoint detector: frame energy accumulation and start/end tracking.
// Depends on sed_pkg.
// Takes one signed sample per beat, one beat per cycle while in_tready is
// high. Each beat that closes a frame yields one result beat carrying the
// frame energy (sum of absolute sample values), the frame number, the
// threshold decision and the running speech start and end frames; tlast
// marks the final result of a detection, after which beats are dropped
// until one arrives with the restart flag in tuser. All work for a beat is
// one accumulate, one compare and the frame bookkeeping, done in the cycle
// the beat is taken; results sit in an output register backed by one skid
// entry, so input is held off only when both are full. Configuration writes
// are always accepted and should be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module speech_endpoint_detector_top #(
  parameter int MAX_FRAME_LENGTH = sed_pkg::MAX_FRAME_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // tdata: sample[15:0]
  input  wire logic [sed_pkg::SAMPLE_W-1:0]   in_tdata,
  // tuser: restart[0]
  input  wire logic                           in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: frame_energy[25:0], frame_index[35:26], above_threshold[36],
  //        speech_found[37], speech_start[47:38], speech_end[57:48], zeros above
  output logic [sed_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tlast: done_res
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sed_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_FRAME_LENGTH);
  localparam int LW = (CW + 1 > sed_pkg::FRAME_LEN_W) ? CW + 1 : sed_pkg::FRAME_LEN_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_FRAME_LENGTH);

  localparam int EW = sed_pkg::ENERGY_W;
  localparam int FW = sed_pkg::FRAME_IDX_W;
  localparam int HW = sed_pkg::HANGOVER_W;
  localparam int SAMPLE_W_L = sed_pkg::SAMPLE_W + 1;

  // configuration registers
  logic [sed_pkg::FRAME_LEN_W-1:0] frame_length_r;
  logic [EW-1:0]                   threshold_r;
  logic [HW-1:0]                   hangover_r;
  logic [FW-1:0]                   window_r;

  // detection state
  logic [CW-1:0] sample_count_r, sample_count_nxt;
  logic [EW-1:0] energy_sum_r, energy_sum_nxt;
  logic [FW-1:0] frame_count_r, frame_count_nxt;
  logic          started_r, started_nxt;
  logic [FW-1:0] start_frame_r, start_frame_nxt;
  logic [FW-1:0] end_frame_r, end_frame_nxt;
  logic          end_seen_r, end_seen_nxt;
  logic [HW-1:0] low_run_r, low_run_nxt;
  logic          finished_r, finished_nxt;

  // output register and skid entry
  sed_pkg::result_t out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             res_valid;

  logic          in_acc;
  logic          restart;
  logic [CW-1:0] sc_cur;
  logic [EW-1:0] es_cur;
  logic [FW-1:0] fc_cur;
  logic          st_cur, es_seen_cur, fin_cur;
  logic [FW-1:0] sf_cur, ef_cur;
  logic [HW-1:0] lr_cur;

  logic [SAMPLE_W_L-1:0] mag;
  logic [EW:0]   energy_wide;
  logic [EW-1:0] energy;
  logic [LW-1:0] len, len_raw, sc_plus;
  logic          frame_end, above;
  logic [FW-1:0] win;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign restart   = in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= sed_pkg::FRAME_LEN_RST;
      threshold_r    <= sed_pkg::THRESHOLD_RST;
      hangover_r     <= sed_pkg::HANGOVER_RST;
      window_r       <= sed_pkg::WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sed_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_data[sed_pkg::FRAME_LEN_W-1:0];
        sed_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[EW-1:0];
        sed_pkg::REG_HANGOVER:     hangover_r     <= cfg_data[HW-1:0];
        sed_pkg::REG_WINDOW:       window_r       <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // restart clears state ahead of the sample
    sc_cur      = restart ? '0 : sample_count_r;
    es_cur      = restart ? '0 : energy_sum_r;
    fc_cur      = restart ? '0 : frame_count_r;
    st_cur      = restart ? 1'b0 : started_r;
    sf_cur      = restart ? '0 : start_frame_r;
    ef_cur      = restart ? '0 : end_frame_r;
    es_seen_cur = restart ? 1'b0 : end_seen_r;
    lr_cur      = restart ? '0 : low_run_r;
    fin_cur     = restart ? 1'b0 : finished_r;

    mag = in_tdata[sed_pkg::SAMPLE_W-1]
        ? SAMPLE_W_L'(-$signed({in_tdata[sed_pkg::SAMPLE_W-1], in_tdata}))
        : {1'b0, in_tdata};
    energy_wide = {1'b0, es_cur} + (EW + 1)'(mag);
    energy      = energy_wide[EW] ? sed_pkg::ENERGY_MAX : energy_wide[EW-1:0];

    len_raw = LW'(frame_length_r);
    if (len_raw == '0) begin
      len = LW'(1);
    end else if (len_raw > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = len_raw;
    end
    sc_plus   = LW'(sc_cur) + LW'(1);
    frame_end = !(sc_plus < len);
    above     = energy > threshold_r;
    win       = (window_r == '0) ? FW'(1) : window_r;

    sample_count_nxt = sc_cur;
    energy_sum_nxt   = es_cur;
    frame_count_nxt  = fc_cur;
    started_nxt      = st_cur;
    start_frame_nxt  = sf_cur;
    end_frame_nxt    = ef_cur;
    end_seen_nxt     = es_seen_cur;
    low_run_nxt      = lr_cur;
    finished_nxt     = fin_cur;
    res_valid        = 1'b0;

    if (!fin_cur) begin
      if (!frame_end) begin
        sample_count_nxt = sc_plus[CW-1:0];
        energy_sum_nxt   = energy;
      end else begin
        res_valid        = 1'b1;
        sample_count_nxt = '0;
        energy_sum_nxt   = '0;
        if (!st_cur) begin
          if (above) begin
            started_nxt     = 1'b1;
            start_frame_nxt = fc_cur;
          end
        end else if (above) begin
          end_seen_nxt = 1'b0;
          low_run_nxt  = '0;
        end else begin
          if (!es_seen_cur) begin
            end_seen_nxt  = 1'b1;
            end_frame_nxt = fc_cur;
            low_run_nxt   = '0;
          end else if (lr_cur != sed_pkg::LOW_RUN_MAX) begin
            low_run_nxt = lr_cur + HW'(1);
          end
          if (low_run_nxt >= hangover_r) begin
            finished_nxt = 1'b1;
          end
        end
        frame_count_nxt = fc_cur + FW'(1);
        if (frame_count_nxt >= win) begin
          finished_nxt = 1'b1;
        end
      end
    end

    res.frame_energy    = energy;
    res.frame_index     = fc_cur;
    res.above_threshold = above;
    res.speech_found    = started_nxt;
    res.speech_start    = start_frame_nxt;
    res.speech_end      = end_frame_nxt;
    res.done_res        = finished_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      energy_sum_r   <= '0;
      frame_count_r  <= '0;
      started_r      <= 1'b0;
      start_frame_r  <= '0;
      end_frame_r    <= '0;
      end_seen_r     <= 1'b0;
      low_run_r      <= '0;
      finished_r     <= 1'b0;
    end else if (in_acc) begin
      sample_count_r <= sample_count_nxt;
      energy_sum_r   <= energy_sum_nxt;
      frame_count_r  <= frame_count_nxt;
      started_r      <= started_nxt;
      start_frame_r  <= start_frame_nxt;
      end_frame_r    <= end_frame_nxt;
      end_seen_r     <= end_seen_nxt;
      low_run_r      <= low_run_nxt;
      finished_r     <= finished_nxt;
    end
  end

  logic push, out_free;
  assign push     = in_acc && res_valid;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || push;
        skid_valid_r <= skid_valid_r && push;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end
    if (push && (skid_valid_r || !out_free)) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.done_res;
  assign out_tdata  = sed_pkg::OUT_DATA_W'({out_r.speech_end, out_r.speech_start,
                                            out_r.speech_found, out_r.above_threshold,
                                            out_r.frame_index, out_r.frame_energy});

endmodule

`default_nettype wire

### tb/sv/speech_endpoint_detector_checker.sv
// Scoreboard for speech_endpoint_detector_top: watches all three channels,
// predicts each frame result from the accepted sample beats and compares it.
// Depends on sed_pkg.
`timescale 1ns / 1ps

module speech_endpoint_detector_checker #(
  parameter int MAX_FRAME_LENGTH = sed_pkg::MAX_FRAME_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: sample[15:0]
  input  logic [sed_pkg::SAMPLE_W-1:0]   in_tdata,
  // tuser: restart[0]
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // tdata: frame_energy, frame_index, above_threshold, speech_found,
  //        speech_start, speech_end, zeros above
  input  logic [sed_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  localparam int RES_W = $bits(sed_pkg::result_t);

  logic [sed_pkg::FRAME_LEN_W-1:0] cfg_len;
  logic [sed_pkg::ENERGY_W-1:0]    cfg_thr;
  logic [sed_pkg::HANGOVER_W-1:0]  cfg_hang;
  logic [sed_pkg::FRAME_IDX_W-1:0] cfg_win;

  logic [sed_pkg::FRAME_IDX_W-1:0] smp_count;
  logic [sed_pkg::ENERGY_W-1:0]    acc;
  logic [sed_pkg::FRAME_IDX_W-1:0] frame_cnt;
  logic                            spk_started;
  logic [sed_pkg::FRAME_IDX_W-1:0] start_frame;
  logic [sed_pkg::FRAME_IDX_W-1:0] end_frame;
  logic                            in_low;
  logic [sed_pkg::HANGOVER_W-1:0]  low_run;
  logic                            det_finished;

  sed_pkg::result_t expected_frames[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic clear_detection();
    smp_count    = '0;
    acc          = '0;
    frame_cnt    = '0;
    spk_started  = 1'b0;
    start_frame  = '0;
    end_frame    = '0;
    in_low       = 1'b0;
    low_run      = '0;
    det_finished = 1'b0;
  endtask

  task automatic predict_sample(input logic [sed_pkg::SAMPLE_W-1:0] smp, input logic rs);
    logic [16:0]                     mag;
    logic [sed_pkg::ENERGY_W:0]      sum;
    logic [sed_pkg::ENERGY_W-1:0]    energy;
    logic [sed_pkg::FRAME_IDX_W-1:0] idx;
    logic                            above;
    int                              len_eff;
    int                              win_eff;
    sed_pkg::result_t                r;
    if (rs) clear_detection();
    if (det_finished) return;
    mag = smp[sed_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    sum = {1'b0, acc} + (sed_pkg::ENERGY_W + 1)'(mag);
    energy = (sum > {1'b0, sed_pkg::ENERGY_MAX}) ? sed_pkg::ENERGY_MAX
                                                 : sum[sed_pkg::ENERGY_W-1:0];
    if (cfg_len == '0) len_eff = 1;
    else if (int'(cfg_len) > MAX_FRAME_LENGTH) len_eff = MAX_FRAME_LENGTH;
    else len_eff = int'(cfg_len);
    if (int'(smp_count) + 1 < len_eff) begin
      smp_count = smp_count + 1'b1;
      acc = energy;
      return;
    end
    smp_count = '0;
    acc = '0;
    idx = frame_cnt;
    above = energy > cfg_thr;
    if (!spk_started) begin
      if (above) begin
        spk_started = 1'b1;
        start_frame = idx;
      end
    end else if (above) begin
      in_low = 1'b0;
      low_run = '0;
    end else begin
      if (!in_low) begin
        in_low = 1'b1;
        end_frame = idx;
        low_run = '0;
      end else if (low_run != sed_pkg::LOW_RUN_MAX) begin
        low_run = low_run + 1'b1;
      end
      if (low_run >= cfg_hang) det_finished = 1'b1;
    end
    frame_cnt = frame_cnt + 1'b1;
    win_eff = (cfg_win == '0) ? 1 : int'(cfg_win);
    if (int'(frame_cnt) >= win_eff) det_finished = 1'b1;
    r.frame_energy    = energy;
    r.frame_index     = idx;
    r.above_threshold = above;
    r.speech_found    = spk_started;
    r.speech_start    = start_frame;
    r.speech_end      = end_frame;
    r.done_res        = det_finished;
    expected_frames.push_back(r);
  endtask

  task automatic compare_frame(input sed_pkg::result_t act);
    sed_pkg::result_t exp_r;
    if (expected_frames.size() == 0) begin
      $error("unexpected result beat: frame_index %0d", act.frame_index);
      fail_count++;
      return;
    end
    exp_r = expected_frames.pop_front();
    if (act.frame_energy !== exp_r.frame_energy) begin
      $error("frame_energy: expected %0d, actual %0d", exp_r.frame_energy, act.frame_energy);
      fail_count++;
    end
    if (act.frame_index !== exp_r.frame_index) begin
      $error("frame_index: expected %0d, actual %0d", exp_r.frame_index, act.frame_index);
      fail_count++;
    end
    if (act.above_threshold !== exp_r.above_threshold) begin
      $error("above_threshold: expected %0d, actual %0d",
             exp_r.above_threshold, act.above_threshold);
      fail_count++;
    end
    if (act.speech_found !== exp_r.speech_found) begin
      $error("speech_found: expected %0d, actual %0d", exp_r.speech_found, act.speech_found);
      fail_count++;
    end
    if (act.speech_start !== exp_r.speech_start) begin
      $error("speech_start: expected %0d, actual %0d", exp_r.speech_start, act.speech_start);
      fail_count++;
    end
    if (act.speech_end !== exp_r.speech_end) begin
      $error("speech_end: expected %0d, actual %0d", exp_r.speech_end, act.speech_end);
      fail_count++;
    end
    if (act.done_res !== exp_r.done_res) begin
      $error("done_res: expected %0d, actual %0d", exp_r.done_res, act.done_res);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_len  = sed_pkg::FRAME_LEN_RST;
      cfg_thr  = sed_pkg::THRESHOLD_RST;
      cfg_hang = sed_pkg::HANGOVER_RST;
      cfg_win  = sed_pkg::WINDOW_RST;
      clear_detection();
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sed_pkg::REG_FRAME_LENGTH: cfg_len  = cfg_data[sed_pkg::FRAME_LEN_W-1:0];
          sed_pkg::REG_THRESHOLD:    cfg_thr  = cfg_data[sed_pkg::ENERGY_W-1:0];
          sed_pkg::REG_HANGOVER:     cfg_hang = cfg_data[sed_pkg::HANGOVER_W-1:0];
          sed_pkg::REG_WINDOW:       cfg_win  = cfg_data[sed_pkg::FRAME_IDX_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (out_tdata[sed_pkg::OUT_DATA_W-1:RES_W-1] !== '0) begin
          $error("tdata padding: expected 0, actual %0h",
                 out_tdata[sed_pkg::OUT_DATA_W-1:RES_W-1]);
          fail_count++;
        end
        compare_frame(sed_pkg::result_t'({out_tlast, out_tdata[RES_W-2:0]}));
        checked++;
      end
    end
    pending = expected_frames.size();
  end

endmodule

### tb/sv/speech_endpoint_detector_top_tb.sv
// Top of the speech endpoint detector testbench: clock, reset, sample and
// register stimulus with random idling, and the verdict.
// Depends on sed_pkg, speech_endpoint_detector_top and its checker.
`timescale 1ns / 1ps

module speech_endpoint_detector_top_tb;

  localparam int LIMIT    = 300000;
  localparam int SETTLE   = 8;
  localparam int HOLD_LEN = 300;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [sed_pkg::SAMPLE_W-1:0]   in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sed_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sed_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  int   checked;
  int   cycles = 0;
  int   beats_sent = 0;
  int   settings = 0;
  logic calm = 1'b0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   done_seen = 0;
  int   done_used = 0;
  int   eff_len = 160;
  int   unit = 2000;
  int   pos = 0;
  logic loud = 1'b0;

  speech_endpoint_detector_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  speech_endpoint_detector_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tlast) done_seen++;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = calm || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_beat(input logic [sed_pkg::SAMPLE_W-1:0] s, input logic rs);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = s;
    in_tuser  = rs;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sed_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sed_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int len, input int thr, input int hang, input int win);
    write_reg(sed_pkg::REG_FRAME_LENGTH, sed_pkg::CFG_DATA_W'(len));
    write_reg(sed_pkg::REG_THRESHOLD, sed_pkg::CFG_DATA_W'(thr));
    write_reg(sed_pkg::REG_HANGOVER, sed_pkg::CFG_DATA_W'(hang));
    write_reg(sed_pkg::REG_WINDOW, sed_pkg::CFG_DATA_W'(win));
    eff_len = (len == 0) ? 1 : (len > sed_pkg::MAX_FRAME_LENGTH_DEF) ?
              sed_pkg::MAX_FRAME_LENGTH_DEF : len;
    settings++;
  endtask

  // frames alternate between loud and quiet runs, with some full-range noise
  task automatic run_phase(input int n, input logic can_restart);
    int                           sent;
    int                           mag;
    logic                         rs;
    logic [sed_pkg::SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < n) begin
      rs = 1'b0;
      if (done_seen != done_used) begin
        rs = 1'b1;
        done_used = done_seen;
      end else if (sent == 0 && !can_restart) begin
        rs = 1'b1;
      end else if (can_restart && $urandom_range(199) == 0) begin
        rs = 1'b1;
      end
      if (rs) pos = 0;
      if (pos == 0 && $urandom_range(99) < 25) loud = !loud;
      if ($urandom_range(99) < 8) begin
        s = sed_pkg::SAMPLE_W'($urandom);
      end else begin
        mag = loud ? int'($urandom_range(unit + 1, 32767)) : int'($urandom_range(0, unit));
        s = sed_pkg::SAMPLE_W'(mag);
        if ($urandom_range(1)) s = -s;
      end
      send_beat(s, rs);
      pos = (pos + 1 >= eff_len) ? 0 : pos + 1;
      sent++;
    end
  endtask

  initial begin
    int len;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset values of all registers
    run_phase(165, 1'b0);

    // directed: field extremes, hangover zero, ignored beats, restart on frame 0
    configure(1, 32767, 0, 1023);
    send_beat(16'd0, 1'b1);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'd5, 1'b0);
    send_beat(16'd100, 1'b0);
    send_beat(16'h8000, 1'b1);
    send_beat(16'h7FFF, 1'b0);
    // later low runs move the end frame
    write_reg(sed_pkg::REG_HANGOVER, sed_pkg::CFG_DATA_W'(2));
    send_beat(16'h8000, 1'b1);
    send_beat(16'h8000, 1'b0);
    send_beat(16'd0, 1'b0);
    send_beat(16'd1, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'd0, 1'b0);
    send_beat(16'd0, 1'b0);
    send_beat(16'd0, 1'b0);
    // frame length and window of zero
    configure(0, 32767, 2, 0);
    send_beat(16'd7, 1'b1);
    send_beat(16'd8, 1'b0);
    send_beat(16'h8000, 1'b1);
    // frame length lowered mid-frame
    configure(4, 32767, 255, 1023);
    send_beat(16'd100, 1'b1);
    send_beat(16'd200, 1'b0);
    send_beat(16'd300, 1'b0);
    write_reg(sed_pkg::REG_FRAME_LENGTH, sed_pkg::CFG_DATA_W'(2));
    send_beat(16'd400, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'd1, 1'b0);

    configure(4, 4 * 8000, 3, 1023);
    unit = 8000;
    run_phase(80, 1'b1);

    calm = 1'b1;
    configure(7, 7 * 3000, 255, 1023);
    unit = 3000;
    run_phase(63, 1'b1);
    calm = 1'b0;

    // long receiver hold-off fills the block, then a full drain pause
    configure(1, 10000, 200, 1023);
    unit = 10000;
    hold_reqs++;
    run_phase(40, 1'b1);
    wait_drained();
    run_phase(40, 1'b1);

    configure(2, 0, 5, 20);
    unit = 50;
    run_phase(60, 1'b1);

    configure(3, 67108863, 2, 50);
    unit = 20000;
    run_phase(36, 1'b1);

    configure(1, 33554432, 1, 1);
    unit = 1000;
    run_phase(24, 1'b1);

    repeat (3) begin
      len = int'($urandom_range(1, 16));
      unit = int'($urandom_range(1, 30000));
      configure(len, len * unit, int'($urandom_range(1, 8)), int'($urandom_range(1, 200)));
      run_phase(35, 1'b1);
    end

    // longest frames, clamped from the largest register value
    configure(2047, 1024 * 8000, 15, 75);
    unit = 8000;
    run_phase(1030, 1'b0);

    wait_drained();
    $display("tb: %0d sample beats over %0d register settings, %0d frame results checked",
             beats_sent, settings, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
